>>> hw/rtl/csvtok_pkg.sv
// csvtok_pkg: word types, state type, character codes and a helper
// function for the CSV row field tokenizer. No dependencies.
`timescale 1ns / 1ps

package csvtok_pkg;

	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;

	typedef enum logic [1:0] {
		TRIM_LEAD = 2'd0,
		TRIM_WORD = 2'd1,
		TRIM_DONE = 2'd2,
		TRIM_XTRA = 2'd3
	} trim_phase_t;

	typedef struct packed {
		logic [7:0] byte_in;
		logic       row_last;
	} in_word_t;

	typedef struct packed {
		logic       char_valid;
		logic [7:0] char_out;
		logic       field_end;
		logic       row_end;
	} out_word_t;

	typedef struct packed {
		logic        in_quote;
		logic        quote_pending;
		trim_phase_t trim_phase;
	} tok_state_t;

	localparam tok_state_t TOK_STATE_RESET = '{
		in_quote: 1'b0, quote_pending: 1'b0, trim_phase: TRIM_LEAD};

	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

endpackage

>>> hw/rtl/csvtok_step.sv
// csvtok_step: combinational next-state and result for one input word.
// Depends on csvtok_pkg.
`timescale 1ns / 1ps

module csvtok_step (
	input  csvtok_pkg::tok_state_t st,
	input  csvtok_pkg::in_word_t   word,
	output csvtok_pkg::tok_state_t st_next,
	output csvtok_pkg::out_word_t  res
);
	import csvtok_pkg::*;

	always_comb begin
		tok_state_t  s;
		logic        handled;
		logic        feed;
		logic [7:0]  feed_ch;
		logic        fe;
		logic        re;
		logic        kept;

		s       = st;
		handled = 1'b0;
		feed    = 1'b0;
		feed_ch = word.byte_in;
		fe      = 1'b0;
		re      = 1'b0;
		kept    = 1'b0;

		if (s.quote_pending) begin
			s.quote_pending = 1'b0;
			if (word.byte_in == CH_QUOTE) begin
				feed    = 1'b1;
				handled = 1'b1;
			end else begin
				s.in_quote = 1'b0;
			end
		end

		if (!handled) begin
			if (s.in_quote) begin
				if (word.byte_in == CH_QUOTE) begin
					s.quote_pending = 1'b1;
				end else begin
					feed = 1'b1;
				end
			end else if (word.byte_in == CH_COMMA) begin
				fe           = 1'b1;
				s.trim_phase = TRIM_LEAD;
			end else if (word.byte_in == CH_QUOTE) begin
				s.in_quote = 1'b1;
			end else if (word.byte_in == CH_LF) begin
				re = 1'b1;
			end else if (word.byte_in != CH_CR) begin
				feed = 1'b1;
			end
		end

		// first-word trim
		if (feed) begin
			case (s.trim_phase)
				TRIM_LEAD: begin
					if (!is_space(feed_ch)) begin
						kept         = 1'b1;
						s.trim_phase = TRIM_WORD;
					end
				end
				TRIM_WORD: begin
					if (is_space(feed_ch)) begin
						s.trim_phase = TRIM_DONE;
					end else begin
						kept = 1'b1;
					end
				end
				default: kept = 1'b0;
			endcase
		end

		if (word.row_last) begin
			re = 1'b1;
		end
		if (re) begin
			s = TOK_STATE_RESET;
		end

		st_next        = s;
		res.char_valid = kept;
		res.char_out   = kept ? feed_ch : 8'h00;
		res.field_end  = fe;
		res.row_end    = re;
	end

endmodule

>>> hw/rtl/csv_row_field_tokenizer_top.sv
// csv_row_field_tokenizer_top: splits CSV rows into trimmed field characters.
// Depends on csvtok_pkg and csvtok_step.
//
//   channel  direction  handshake              word
//   src      in         src_valid / src_stall  in_word_t  {byte_in, row_last}
//   dst      out        dst_valid / dst_stall  out_word_t {char_valid, char_out,
//                                                          field_end, row_end}
//
// One byte per cycle unless dst stalls; dst_valid is set as a word advances.
// Input register, then the tokenizer step, then the result register; the
// tokenizer state advances as a word moves into the result register.
// arst_n clears the valid bits and the tokenizer state at once.
// A dst stall holds the result; src is stalled only while both registers are full.
`timescale 1ns / 1ps

module csv_row_field_tokenizer_top (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  src_valid,
	output logic                  src_stall,
	input  csvtok_pkg::in_word_t  src_data,
	output logic                  dst_valid,
	input  logic                  dst_stall,
	output csvtok_pkg::out_word_t dst_data
);
	import csvtok_pkg::*;

	logic       valid_s1;
	in_word_t   word_s1;
	tok_state_t state_q;
	tok_state_t state_next;
	out_word_t  res;
	logic       out_valid_q;
	out_word_t  out_word_q;
	logic       advance;

	assign advance   = valid_s1 && (!out_valid_q || !dst_stall);
	assign src_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!src_stall) begin
			valid_s1 <= src_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (src_valid && !src_stall) begin
			word_s1 <= src_data;
		end
	end

	csvtok_step u_step (
		.st      (state_q),
		.word    (word_s1),
		.st_next (state_next),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= TOK_STATE_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				state_q     <= state_next;
				out_valid_q <= 1'b1;
			end else if (!dst_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_word_q <= res;
		end
	end

	assign dst_valid = out_valid_q;
	assign dst_data  = out_word_q;

	a_row_end_resets: assert property (@(posedge clk) disable iff (!arst_n)
		advance && res.row_end |=> state_q == TOK_STATE_RESET)
		else $error("tokenizer state not reset after row end");

	a_stall_needs_word: assert property (@(posedge clk) disable iff (!arst_n)
		src_stall |-> valid_s1 && out_valid_q && dst_stall)
		else $error("src stalled without a full pipeline");

	a_char_zero: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && !dst_data.char_valid |-> dst_data.char_out == 8'h00)
		else $error("char_out nonzero without char_valid");

	a_fe_no_char: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid |-> !(dst_data.field_end && dst_data.char_valid))
		else $error("field_end together with a kept character");

endmodule
